/* src/strided_tensor_offset_generator_core_assert.svh */
// ----------------------------------------------------------------------------
// strided_tensor_offset_generator_core_assert
// Assertion macros used by the offset generator core.
// ----------------------------------------------------------------------------
`ifndef STRIDED_TENSOR_OFFSET_GENERATOR_CORE_ASSERT_SVH
`define STRIDED_TENSOR_OFFSET_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stdg_pkg.sv */
// ----------------------------------------------------------------------------
// stdg_pkg
// Shared widths, register indexes and cell structs of the offset generator.
// ----------------------------------------------------------------------------
package stdg_pkg;

  localparam int MAX_DIMS_DEF = 8;
  localparam int OFS_W        = 48;
  localparam int EXT_W        = 32;
  localparam int DIMS_W       = 4;
  localparam int DIM_IDX_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_DIMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_DIMS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_CNT  = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // control broadcast to every dimension cell
  typedef struct packed {
    logic                 load;
    logic [DIM_IDX_W-1:0] dim;
    logic [EXT_W-1:0]     src_extent;
    logic [EXT_W-1:0]     src_step;
    logic [EXT_W-1:0]     dst_extent;
    logic [EXT_W-1:0]     dst_step;
    logic                 start;
    logic [DIMS_W-1:0]    src_first;
    logic [DIMS_W-1:0]    dst_first;
    logic                 src_shift;
    logic                 dst_shift;
  } stdg_cell_ctl_t;

  // entries of a cell, zero unless the cell holds the token
  typedef struct packed {
    logic [EXT_W-1:0] src_ext;
    logic [EXT_W-1:0] src_step;
    logic [EXT_W-1:0] dst_ext;
    logic [EXT_W-1:0] dst_step;
  } stdg_cell_out_t;

endpackage

/* src/stdg_if.sv */
// ----------------------------------------------------------------------------
// stdg_in_if / stdg_out_if
// Valid/ready channels carrying command beats and offset beats.
// ----------------------------------------------------------------------------
interface stdg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  dim_index;
  logic [31:0] src_extent;
  logic [31:0] src_step;
  logic [31:0] dst_extent;
  logic [31:0] dst_step;
  logic [47:0] linear_index;

  modport source (output valid, command, dim_index, src_extent, src_step,
                  dst_extent, dst_step, linear_index, input ready);
  modport sink   (input valid, command, dim_index, src_extent, src_step,
                  dst_extent, dst_step, linear_index, output ready);
endinterface

interface stdg_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] src_offset;
  logic [47:0] dst_offset;
  logic        in_range;

  modport source (output valid, src_offset, dst_offset, in_range, input ready);
  modport sink   (input valid, src_offset, dst_offset, in_range, output ready);
endinterface

/* src/strided_tensor_offset_generator_core.sv */
// ----------------------------------------------------------------------------
// strided_tensor_offset_generator_core
// Maps a linear element index to source and destination offsets.
// ----------------------------------------------------------------------------
// A load beat (command 0) writes one dimension's extent and stride entries for
// both layouts and returns an all-zero result beat in the next cycle. A compute
// beat (command 1) walks the dimensions from the innermost outward: a token
// steps down a row of dimension cells, and for each dimension other than 0 a
// bit-serial divider splits the index, then it multiplies and accumulates;
// dimension 0 takes a select, two 32-bit partial products and two adds.
// One beat is in flight at a time; a finished beat waits in the output register
// and holds off the next beat until it is taken.
// Offsets wrap at 48 bits; in_range flags linear_index below element_count.
module strided_tensor_offset_generator_core
  import stdg_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  stdg_in_if.sink               in_bus,
  stdg_out_if.source            out_bus
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [DIMS_W-1:0] src_dims_r, dst_dims_r;
  logic [OFS_W-1:0]  elem_cnt_r;

  logic              st_r;
  logic              out_valid_r;
  logic [OFS_W-1:0]  out_src_r, out_dst_r;
  logic              out_rng_r, rng_r;
  logic              out_free, in_acc, cmp_acc, fin;

  stdg_cell_ctl_t    ctl;
  stdg_cell_out_t    ent [MAX_DIMS];
  logic [MAX_DIMS:0] src_tok, dst_tok;
  stdg_cell_out_t    sel;

  logic              src_shift, dst_shift, src_done, dst_done;
  logic [OFS_W-1:0]  src_acc, dst_acc;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_dims_r <= DIMS_W'(1);
      dst_dims_r <= DIMS_W'(1);
      elem_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_DIMS: src_dims_r <= cfg_data[DIMS_W-1:0];
        CFG_DST_DIMS: dst_dims_r <= cfg_data[DIMS_W-1:0];
        CFG_ELEM_CNT: elem_cnt_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // index of the innermost dimension walked, dims clamped to 1..MAX_DIMS
  function automatic logic [DIMS_W-1:0] first_dim(input logic [DIMS_W-1:0] d);
    logic [DIMS_W:0] dx;
    dx = {1'b0, d};
    if (dx == '0)                         return '0;
    else if (dx > (DIMS_W+1)'(MAX_DIMS))  return DIMS_W'(MAX_DIMS - 1);
    else                                  return DIMS_W'(dx - (DIMS_W+1)'(1));
  endfunction

  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (st_r == ST_IDLE) && out_free;
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign cmp_acc = in_acc && (in_bus.command == CMD_COMPUTE);
  assign fin     = (st_r == ST_RUN) && src_done && dst_done && out_free;

  // broadcast to the cell row
  assign ctl.load       = in_acc && (in_bus.command == CMD_LOAD);
  assign ctl.dim        = in_bus.dim_index;
  assign ctl.src_extent = in_bus.src_extent;
  assign ctl.src_step   = in_bus.src_step;
  assign ctl.dst_extent = in_bus.dst_extent;
  assign ctl.dst_step   = in_bus.dst_step;
  assign ctl.start      = cmp_acc;
  assign ctl.src_first  = first_dim(src_dims_r);
  assign ctl.dst_first  = first_dim(dst_dims_r);
  assign ctl.src_shift  = src_shift;
  assign ctl.dst_shift  = dst_shift;

  // tokens travel from the top cell towards cell 0
  assign src_tok[MAX_DIMS] = 1'b0;
  assign dst_tok[MAX_DIMS] = 1'b0;

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
    stdg_dim_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .src_tok_up (src_tok[g+1]),
      .dst_tok_up (dst_tok[g+1]),
      .src_tok    (src_tok[g]),
      .dst_tok    (dst_tok[g]),
      .ent        (ent[g])
    );
  end

  // only the token holder drives non-zero entries
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_DIMS; i++) sel = sel | ent[i];
  end

  stdg_engine u_src_eng (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_acc),
    .idx_in (in_bus.linear_index),
    .ext    (sel.src_ext),
    .step   (sel.src_step),
    .last   (src_tok[0]),
    .shift  (src_shift),
    .done   (src_done),
    .acc    (src_acc)
  );

  stdg_engine u_dst_eng (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_acc),
    .idx_in (in_bus.linear_index),
    .ext    (sel.dst_ext),
    .step   (sel.dst_step),
    .last   (dst_tok[0]),
    .shift  (dst_shift),
    .done   (dst_done),
    .acc    (dst_acc)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmp_acc)  st_r <= ST_RUN;
      else if (fin) st_r <= ST_IDLE;
      if (ctl.load || fin)    out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // result beat and range flag
  always_ff @(posedge clk) begin
    if (cmp_acc) rng_r <= (in_bus.linear_index < elem_cnt_r);
    if (ctl.load) begin
      out_src_r <= '0;
      out_dst_r <= '0;
      out_rng_r <= 1'b0;
    end else if (fin) begin
      out_src_r <= src_acc;
      out_dst_r <= dst_acc;
      out_rng_r <= rng_r;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.src_offset = out_src_r;
  assign out_bus.dst_offset = out_dst_r;
  assign out_bus.in_range   = out_rng_r;

`include "strided_tensor_offset_generator_core_assert.svh"

  `STDG_ASSERT_NOW(a_ready_idle, in_bus.ready, st_r == ST_IDLE, "ready outside idle")
  `STDG_ASSERT_NEXT(a_load_beat, ctl.load, out_valid_r && (out_src_r == '0), "load beat lost")
  `STDG_ASSERT_NEXT(a_cmp_run, cmp_acc, (st_r == ST_RUN) && !src_done && !dst_done, "no run")
  `STDG_ASSERT_NOW(a_tok_one, st_r == ST_RUN, $onehot0(src_tok) && $onehot0(dst_tok), "tokens")

endmodule

/* src/stdg_dim_cell.sv */
// ----------------------------------------------------------------------------
// stdg_dim_cell
// One dimension: extent/stride entries of both layouts plus the walk tokens.
// ----------------------------------------------------------------------------
module stdg_dim_cell
  import stdg_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  stdg_cell_ctl_t ctl,
  input  logic           src_tok_up,
  input  logic           dst_tok_up,
  output logic           src_tok,
  output logic           dst_tok,
  output stdg_cell_out_t ent
);

  logic [EXT_W-1:0] src_ext_r, src_step_r, dst_ext_r, dst_step_r;
  logic             src_tok_r, dst_tok_r;
  logic             wr_hit;

  assign wr_hit = ctl.load && ({1'b0, ctl.dim} == 4'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ext_r  <= EXT_W'(1);
      src_step_r <= '0;
      dst_ext_r  <= EXT_W'(1);
      dst_step_r <= '0;
    end else if (wr_hit) begin
      // a zero extent is held as one
      src_ext_r  <= (ctl.src_extent == '0) ? EXT_W'(1) : ctl.src_extent;
      src_step_r <= ctl.src_step;
      dst_ext_r  <= (ctl.dst_extent == '0) ? EXT_W'(1) : ctl.dst_extent;
      dst_step_r <= ctl.dst_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_tok_r <= 1'b0;
      dst_tok_r <= 1'b0;
    end else begin
      if (ctl.start)          src_tok_r <= (ctl.src_first == 4'(IDX));
      else if (ctl.src_shift) src_tok_r <= src_tok_up;
      if (ctl.start)          dst_tok_r <= (ctl.dst_first == 4'(IDX));
      else if (ctl.dst_shift) dst_tok_r <= dst_tok_up;
    end
  end

  assign src_tok      = src_tok_r;
  assign dst_tok      = dst_tok_r;
  assign ent.src_ext  = src_tok_r ? src_ext_r  : '0;
  assign ent.src_step = src_tok_r ? src_step_r : '0;
  assign ent.dst_ext  = dst_tok_r ? dst_ext_r  : '0;
  assign ent.dst_step = dst_tok_r ? dst_step_r : '0;

endmodule

/* src/stdg_engine.sv */
// ----------------------------------------------------------------------------
// stdg_engine
// Bit-serial divide plus multiply-accumulate for one layout.
// ----------------------------------------------------------------------------
module stdg_engine
  import stdg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFS_W-1:0] idx_in,
  input  logic [EXT_W-1:0] ext,
  input  logic [EXT_W-1:0] step,
  input  logic             last,
  output logic             shift,
  output logic             done,
  output logic [OFS_W-1:0] acc
);

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_SEL   = 3'd1;
  localparam logic [2:0] E_DIV   = 3'd2;
  localparam logic [2:0] E_MUL   = 3'd3;
  localparam logic [2:0] E_ADD   = 3'd4;
  localparam logic [2:0] E_MULHI = 3'd5;
  localparam logic [2:0] E_ADDHI = 3'd6;
  localparam logic [2:0] E_DONE  = 3'd7;

  localparam int CNT_W = $clog2(OFS_W);

  logic [2:0]         st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [OFS_W-1:0]   quo_r, acc_r;
  logic [EXT_W-1:0]   rem_r;
  logic [2*EXT_W-1:0] prod_r;
  logic [EXT_W:0]     shifted, diff;
  logic               ge;
  logic [EXT_W-1:0]   mul_a;

  assign shifted = {rem_r, quo_r[OFS_W-1]};
  assign ge      = shifted >= {1'b0, ext};
  assign diff    = shifted - {1'b0, ext};

  always_comb begin
    mul_a = rem_r;
    if (st_r == E_MULHI)  mul_a = EXT_W'(quo_r[OFS_W-1:EXT_W]);
    else if (last)        mul_a = quo_r[EXT_W-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      E_IDLE:  st_nxt = E_IDLE;
      E_SEL:   st_nxt = last ? E_MUL : E_DIV;
      E_DIV:   st_nxt = (cnt_r == CNT_W'(OFS_W-1)) ? E_MUL : E_DIV;
      E_MUL:   st_nxt = E_ADD;
      E_ADD:   st_nxt = last ? E_MULHI : E_SEL;
      E_MULHI: st_nxt = E_ADDHI;
      E_ADDHI: st_nxt = E_DONE;
      E_DONE:  st_nxt = E_DONE;
      default: st_nxt = E_IDLE;
    endcase
    if (start) st_nxt = E_SEL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= E_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= idx_in;
      rem_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        E_DIV: begin
          quo_r <= {quo_r[OFS_W-2:0], ge};
          rem_r <= ge ? diff[EXT_W-1:0] : shifted[EXT_W-1:0];
          cnt_r <= cnt_r + CNT_W'(1);
        end
        E_ADD: begin
          acc_r <= acc_r + prod_r[OFS_W-1:0];
          rem_r <= '0;
          cnt_r <= '0;
        end
        E_ADDHI: acc_r <= acc_r + {prod_r[OFS_W-EXT_W-1:0], {EXT_W{1'b0}}};
        default: ;
      endcase
    end
    prod_r <= mul_a * step;
  end

  assign shift = (st_r == E_ADD) && !last;
  assign done  = (st_r == E_DONE);
  assign acc   = acc_r;

endmodule

/* tb/sv/strided_tensor_offset_generator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_tensor_offset_generator_core_tb
// Self-checking bench for the strided offset generator. Load and compute beats
// go in through the command channel and the bench works out the offset beats
// it should see. Each returned beat is checked field by field, in order,
// against that prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module strided_tensor_offset_generator_core_tb;
  import stdg_pkg::*;

  localparam int NUM_ITEMS   = 1550;
  localparam int STALL_LIMIT = 4000;  // well above the worst beat and the long hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 400;

  typedef struct packed {
    logic                 command;
    logic [DIM_IDX_W-1:0] dim_index;
    logic [EXT_W-1:0]     src_extent;
    logic [EXT_W-1:0]     src_step;
    logic [EXT_W-1:0]     dst_extent;
    logic [EXT_W-1:0]     dst_step;
    logic [OFS_W-1:0]     linear_index;
  } cmd_beat_t;

  localparam int CMD_W = $bits(cmd_beat_t);

  typedef struct packed {
    logic [OFS_W-1:0] src_offset;
    logic [OFS_W-1:0] dst_offset;
    logic             in_range;
  } ofs_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the dimension tables and registers, queues the offset
  // beats each accepted command beat should produce.
  // --------------------------------------------------------------------------
  class offset_scoreboard;
    bit [EXT_W-1:0]   src_ext_tbl [MAX_DIMS_DEF];
    bit [EXT_W-1:0]   src_step_tbl[MAX_DIMS_DEF];
    bit [EXT_W-1:0]   dst_ext_tbl [MAX_DIMS_DEF];
    bit [EXT_W-1:0]   dst_step_tbl[MAX_DIMS_DEF];
    bit [DIMS_W-1:0]  src_dims;
    bit [DIMS_W-1:0]  dst_dims;
    bit [OFS_W-1:0]   elem_count;
    ofs_beat_t        pending_offsets[$];
    int               mismatches;

    function void clear();
      for (int i = 0; i < MAX_DIMS_DEF; i++) begin
        src_ext_tbl[i]  = 1;
        src_step_tbl[i] = 0;
        dst_ext_tbl[i]  = 1;
        dst_step_tbl[i] = 0;
      end
      src_dims   = 1;
      dst_dims   = 1;
      elem_count = 0;
      pending_offsets.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SRC_DIMS: src_dims   = data[DIMS_W-1:0];
        CFG_DST_DIMS: dst_dims   = data[DIMS_W-1:0];
        CFG_ELEM_CNT: elem_count = data[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    // split the index innermost first; outermost quotient takes stride 0 as is
    function bit [OFS_W-1:0] walk_dims(bit [OFS_W-1:0] idx, bit [DIMS_W-1:0] dims_reg,
                                       bit [EXT_W-1:0] ext[MAX_DIMS_DEF],
                                       bit [EXT_W-1:0] stp[MAX_DIMS_DEF]);
      bit [OFS_W-1:0] acc;
      bit [OFS_W-1:0] e;
      bit [OFS_W-1:0] q;
      bit [OFS_W-1:0] r;
      int             dims;
      dims = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_reg;
      acc  = '0;
      for (int k = dims - 1; k >= 1; k--) begin
        e   = (ext[k] == 0) ? 48'd1 : {16'd0, ext[k]};
        q   = idx / e;
        r   = idx - q * e;
        acc = acc + r * {16'd0, stp[k]};
        idx = q;
      end
      acc = acc + idx * {16'd0, stp[0]};
      return acc;
    endfunction

    function void note_command(cmd_beat_t c);
      ofs_beat_t o;
      o = '0;
      if (c.command == CMD_LOAD) begin
        src_ext_tbl[c.dim_index]  = (c.src_extent == 0) ? 32'd1 : c.src_extent;
        src_step_tbl[c.dim_index] = c.src_step;
        dst_ext_tbl[c.dim_index]  = (c.dst_extent == 0) ? 32'd1 : c.dst_extent;
        dst_step_tbl[c.dim_index] = c.dst_step;
      end else begin
        o.src_offset = walk_dims(c.linear_index, src_dims, src_ext_tbl, src_step_tbl);
        o.dst_offset = walk_dims(c.linear_index, dst_dims, dst_ext_tbl, dst_step_tbl);
        o.in_range   = (c.linear_index < elem_count);
      end
      pending_offsets.push_back(o);
    endfunction

    function void check_offsets(ofs_beat_t got);
      ofs_beat_t exp_o;
      if (pending_offsets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected offset beat src=%h dst=%h rng=%b", $realtime,
                   got.src_offset, got.dst_offset, got.in_range);
        return;
      end
      exp_o = pending_offsets.pop_front();
      if (got.src_offset !== exp_o.src_offset || got.dst_offset !== exp_o.dst_offset ||
          got.in_range !== exp_o.in_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp src=%h dst=%h rng=%b got src=%h dst=%h rng=%b",
                   $realtime, exp_o.src_offset, exp_o.dst_offset, exp_o.in_range,
                   got.src_offset, got.dst_offset, got.in_range);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stdg_in_if  cmd_bus ();
  stdg_out_if ofs_bus ();

  strided_tensor_offset_generator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_bus   (cmd_bus.sink),
    .out_bus  (ofs_bus.source)
  );

  offset_scoreboard sb;
  int cmd_beats;     // accepted command beats
  int ofs_beats;     // accepted offset beats
  int idle_run;      // cycles since the last beat on either channel
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: check on acceptance, then pick next ready. One long hold-off
  // after a couple of hundred beats lets the block fill and push back.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && ofs_bus.valid && ofs_bus.ready) begin
      sb.check_offsets({ofs_bus.src_offset, ofs_bus.dst_offset, ofs_bus.in_range});
      ofs_beats++;
    end
    if (!rst_n) begin
      ofs_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ofs_bus.ready <= 1'b0;
    end else if (!hold_done && ofs_beats >= 200) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      ofs_bus.ready <= 1'b0;
    end else if (ofs_beats >= 600 && ofs_beats < 800) begin
      ofs_bus.ready <= 1'b1;   // stretch with no stalls
    end else begin
      ofs_bus.ready <= ($urandom_range(99) >= 28);
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (ofs_bus.valid && ofs_bus.ready))
      idle_run = 0;
    else
      idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one beat and hold it until taken
  task automatic send_cmd(cmd_beat_t c);
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= c.command;
    cmd_bus.dim_index    <= c.dim_index;
    cmd_bus.src_extent   <= c.src_extent;
    cmd_bus.src_step     <= c.src_step;
    cmd_bus.dst_extent   <= c.dst_extent;
    cmd_bus.dst_step     <= c.dst_step;
    cmd_bus.linear_index <= c.linear_index;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_command(c);
    cmd_beats++;
    // random gap outside the no-idle stretch
    if (!(cmd_beats >= 600 && cmd_beats < 800) && $urandom_range(99) < 28) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_offsets.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_beat_t load_beat(int dim, logic [31:0] se, logic [31:0] ss,
                                          logic [31:0] de, logic [31:0] ds);
    cmd_beat_t c;
    c = '0;
    c.command      = CMD_LOAD;
    c.dim_index    = DIM_IDX_W'(dim);
    c.src_extent   = se;
    c.src_step     = ss;
    c.dst_extent   = de;
    c.dst_step     = ds;
    c.linear_index = OFS_W'({$urandom, $urandom});   // ignored by a load
    return c;
  endfunction

  function automatic cmd_beat_t compute_beat(logic [OFS_W-1:0] idx);
    cmd_beat_t c;
    // noise in unused fields
    c = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    c.command      = CMD_COMPUTE;
    c.linear_index = idx;
    return c;
  endfunction

  // extents: mostly small so that remainders matter, with zero and full range
  function automatic logic [31:0] rand_extent();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(16, 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'd0;
      default: return $urandom_range(4096);
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] rand_index();
    case ($urandom_range(5))
      0:       return OFS_W'({$urandom, $urandom});
      1:       return {16'hFFFF, $urandom};
      2:       return 48'hFFFF_FFFF_FFFF;
      default: return OFS_W'($urandom_range(100000));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int               phase_len;
    logic [OFS_W-1:0] cnt;
    sb = new();
    sb.clear();
    cmd_beats = 0;
    ofs_beats = 0;
    idle_run  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = CMD_LOAD;
    cmd_bus.dim_index    = '0;
    cmd_bus.src_extent   = '0;
    cmd_bus.src_step     = '0;
    cmd_bus.dst_extent   = '0;
    cmd_bus.dst_step     = '0;
    cmd_bus.linear_index = '0;
    ofs_bus.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tables: single dimension, stride 0, nothing in range
    send_cmd(compute_beat(48'hFFFF_FFFF_FFFF));
    send_cmd(compute_beat(48'd0));
    wait_drained();

    write_reg(CFG_SRC_DIMS, 48'd8);
    write_reg(CFG_DST_DIMS, 48'd3);
    write_reg(CFG_ELEM_CNT, 48'd1000);
    end_writes();
    // zero extents stored as one, full-range extents and strides
    send_cmd(load_beat(0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
    send_cmd(load_beat(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
    for (int d = 2; d < MAX_DIMS_DEF; d++)
      send_cmd(load_beat(d, d + 1, 32'd1 << d, 32'd5, 32'd7 * d));
    send_cmd(compute_beat(48'd0));
    send_cmd(compute_beat(48'd999));                // last in range
    send_cmd(compute_beat(48'd1000));               // first out of range
    send_cmd(compute_beat(48'hFFFF_FFFF_FFFF));     // wraps the offsets
    wait_drained();

    // dimension counts zero and above the table depth
    write_reg(CFG_SRC_DIMS, 48'hFFFF_FFFF_FFF0);
    write_reg(CFG_DST_DIMS, 48'h0000_0000_000F);
    write_reg(CFG_ELEM_CNT, 48'hFFFF_FFFF_FFFF);
    end_writes();
    send_cmd(compute_beat(48'h1234_5678_9ABC));
    send_cmd(compute_beat(48'hFFFF_FFFF_FFFE));
    send_cmd(compute_beat(48'hFFFF_FFFF_FFFF));
    wait_drained();

    // random phases, reconfigured between them once idle
    while (cmd_beats < NUM_ITEMS) begin
      case ($urandom_range(7))
        0:       cnt = OFS_W'({$urandom, $urandom});
        1:       cnt = 48'd0;
        2:       cnt = 48'hFFFF_FFFF_FFFF;
        default: cnt = OFS_W'($urandom_range(200000));
      endcase
      write_reg(CFG_SRC_DIMS, ($urandom_range(9) == 0) ? CFG_DATA_W'({$urandom, $urandom})
                                                      : CFG_DATA_W'($urandom_range(8, 1)));
      write_reg(CFG_DST_DIMS, ($urandom_range(9) == 0) ? CFG_DATA_W'({$urandom, $urandom})
                                                      : CFG_DATA_W'($urandom_range(8, 1)));
      write_reg(CFG_ELEM_CNT, cnt);
      end_writes();
      phase_len = $urandom_range(80, 30);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(99) < 35)
          send_cmd(load_beat($urandom_range(MAX_DIMS_DEF - 1), rand_extent(), rand_step(),
                             rand_extent(), rand_step()));
        else
          send_cmd(compute_beat(rand_index()));
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_offsets.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/stdg_pkg.sv
src/stdg_if.sv
src/stdg_dim_cell.sv
src/stdg_engine.sv
src/strided_tensor_offset_generator_core.sv
tb/sv/strided_tensor_offset_generator_core_tb.sv
